// ===== rtl/dfsc_pkg.sv =====
// Shared constants, codes and controller/datapath command types for the DFS cycle checker.
package dfsc_pkg;

    localparam int NODES  = 16;
    localparam int NODE_W = 4;
    localparam int CNT_W  = $clog2(NODES + 1);

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [1:0]        t_code;

    localparam t_code OP_DECLARE = 2'd0;
    localparam t_code OP_EDGE    = 2'd1;
    localparam t_code OP_RUN     = 2'd2;
    localparam t_code OP_CLEAR   = 2'd3;

    localparam t_code KIND_POST       = 2'd0;
    localparam t_code KIND_PATH       = 2'd1;
    localparam t_code KIND_DONE_ACYC  = 2'd2;
    localparam t_code KIND_DONE_CYCLE = 2'd3;

    localparam t_code COLOR_WHITE = 2'd0;
    localparam t_code COLOR_GRAY  = 2'd1;
    localparam t_code COLOR_BLACK = 2'd2;

    typedef enum logic [1:0] {
        NSEL_ZERO,
        NSEL_TOP,
        NSEL_PATH,
        NSEL_START
    } t_nsel;

    typedef struct packed {
        logic  run_init;
        logic  root_rd;
        logic  root_adv;
        logic  root_take;
        logic  scan_adv;
        logic  push;
        logic  pop;
        logic  gray_hit;
        logic  k_rd;
        logic  k_inc;
        logic  emit;
        t_code kind;
        t_nsel nsel;
        logic  last;
    } t_dp_cmd;

    typedef struct packed {
        logic root_end;
        logic root_ok;
        logic scan_end;
        logic edge_white;
        logic edge_gray;
        logic depth_one;
        logic k_end;
        logic k_match;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/dfsc_if.sv =====
// Handshake interfaces for the command item channel and the result channel.
interface dfsc_item_if import dfsc_pkg::*;;
    logic  valid;
    logic  ready;
    t_code opcode;
    t_node src_node;
    t_node dst_node;

    modport source (output valid, output opcode, output src_node, output dst_node,
                    input ready);
    modport sink   (input valid, input opcode, input src_node, input dst_node,
                    output ready);
endinterface

interface dfsc_result_if import dfsc_pkg::*;;
    logic  valid;
    logic  ready;
    t_code kind;
    t_node node;
    logic  last;

    modport source (output valid, output kind, output node, output last, input ready);
    modport sink   (input valid, input kind, input node, input last, output ready);
endinterface

// ===== rtl/dfsc_dp.sv =====
// Datapath: graph storage, colors, search stack, cycle path pointer and result register.
module dfsc_dp import dfsc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_code    i_opcode,
    input  t_node    i_src,
    input  t_node    i_dst,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_code    o_kind,
    output t_node    o_node,
    output logic     o_last
);

    logic [NODES-1:0] r_adj [NODES];
    logic [NODES-1:0] r_decl;
    t_code            r_color [NODES];
    t_node            r_stk_node [NODES];
    t_cnt             r_stk_next [NODES];
    t_cnt             r_depth;
    t_node            r_cstart;
    t_cnt             r_root;
    t_cnt             r_k;
    logic             r_ov;
    t_code            r_kind;
    t_node            r_node;
    logic             r_last;

    t_node w_top_idx;
    t_node w_rd_idx;
    t_node w_rd_node;
    t_cnt  w_rd_next;
    t_node w_nbr;
    t_node w_root_idx;
    t_node w_color_idx;
    t_code w_color;
    logic  w_edge;
    logic  w_src_ok;
    logic  w_dst_ok;
    logic  w_can_push;
    t_node w_emit_node;

    assign w_top_idx   = NODE_W'(r_depth - CNT_W'(1));
    assign w_rd_idx    = i_cmd.k_rd ? r_k[NODE_W-1:0] : w_top_idx;
    assign w_rd_node   = r_stk_node[w_rd_idx];
    assign w_rd_next   = r_stk_next[w_rd_idx];
    assign w_nbr       = w_rd_next[NODE_W-1:0];
    assign w_root_idx  = r_root[NODE_W-1:0];
    assign w_color_idx = i_cmd.root_rd ? w_root_idx : w_nbr;
    assign w_color     = r_color[w_color_idx];
    assign w_edge      = (w_rd_next != CNT_W'(NODES)) && r_adj[w_rd_node][w_nbr];
    assign w_src_ok    = CNT_W'(i_src) < CNT_W'(NODES);
    assign w_dst_ok    = CNT_W'(i_dst) < CNT_W'(NODES);
    assign w_can_push  = r_depth < CNT_W'(NODES);

    always_comb begin
        o_stat.root_end   = r_root == CNT_W'(NODES);
        o_stat.root_ok    = (r_root != CNT_W'(NODES)) && r_decl[w_root_idx] &&
                            (w_color == COLOR_WHITE);
        o_stat.scan_end   = w_rd_next == CNT_W'(NODES);
        o_stat.edge_white = w_edge && (w_color == COLOR_WHITE);
        o_stat.edge_gray  = w_edge && (w_color == COLOR_GRAY);
        o_stat.depth_one  = r_depth == CNT_W'(1);
        o_stat.k_end      = r_k == r_depth;
        o_stat.k_match    = w_rd_node == r_cstart;
        o_stat.out_free   = !r_ov || i_res_ready;
    end

    always_comb begin
        unique case (i_cmd.nsel)
            NSEL_TOP, NSEL_PATH: w_emit_node = w_rd_node;
            NSEL_START:          w_emit_node = r_cstart;
            default:             w_emit_node = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                r_adj[i]   <= '0;
                r_color[i] <= COLOR_WHITE;
            end
            r_decl   <= '0;
            r_depth  <= '0;
            r_cstart <= '0;
            r_root   <= '0;
            r_k      <= '0;
        end else begin
            if (i_load) begin
                unique case (i_opcode)
                    OP_DECLARE: begin
                        if (w_src_ok) r_decl[i_src] <= 1'b1;
                    end
                    OP_EDGE: begin
                        if (w_src_ok && w_dst_ok) begin
                            r_decl[i_src]       <= 1'b1;
                            r_adj[i_src][i_dst] <= 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        for (int i = 0; i < NODES; i++) begin
                            r_adj[i]   <= '0;
                            r_color[i] <= COLOR_WHITE;
                        end
                        r_decl   <= '0;
                        r_depth  <= '0;
                        r_cstart <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.run_init) begin
                for (int i = 0; i < NODES; i++) r_color[i] <= COLOR_WHITE;
                r_depth <= '0;
                r_root  <= '0;
            end
            if (i_cmd.root_adv) r_root <= r_root + CNT_W'(1);
            if (i_cmd.root_take) begin
                r_color[w_root_idx] <= COLOR_GRAY;
                r_depth             <= CNT_W'(1);
            end
            if (i_cmd.push) begin
                r_color[w_nbr] <= COLOR_GRAY;
                if (w_can_push) r_depth <= r_depth + CNT_W'(1);
            end
            if (i_cmd.pop) begin
                r_color[w_rd_node] <= COLOR_BLACK;
                r_depth            <= r_depth - CNT_W'(1);
            end
            if (i_cmd.gray_hit) begin
                r_cstart <= w_nbr;
                r_k      <= '0;
            end
            if (i_cmd.k_inc) r_k <= r_k + CNT_W'(1);
        end
    end

    // Stack entries are written before they are read in every run.
    always_ff @(posedge i_clk) begin
        if (i_cmd.root_take) begin
            r_stk_node[0] <= w_root_idx;
            r_stk_next[0] <= '0;
        end
        if (i_cmd.scan_adv) r_stk_next[w_top_idx] <= w_rd_next + CNT_W'(1);
        if (i_cmd.push && w_can_push) begin
            r_stk_node[r_depth[NODE_W-1:0]] <= w_nbr;
            r_stk_next[r_depth[NODE_W-1:0]] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_res_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind <= i_cmd.kind;
            r_node <= w_emit_node;
            r_last <= i_cmd.last;
        end
    end

    assign o_res_valid = r_ov;
    assign o_kind      = r_kind;
    assign o_node      = r_node;
    assign o_last      = r_last;

endmodule

// ===== rtl/dfsc_ctrl.sv =====
// Controller: sequences root selection, neighbor scan, cycle path walk and status.
module dfsc_ctrl import dfsc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_code    i_opcode,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ROOT  = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_FIND  = 8'b0000_1000,
        S_PATH  = 8'b0001_0000,
        S_CLOSE = 8'b0010_0000,
        S_CYC   = 8'b0100_0000,
        S_ACYC  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_opcode == OP_RUN) begin
                    o_cmd.run_init = 1'b1;
                    n_state        = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.root_rd = 1'b1;
                if (i_stat.root_end) begin
                    n_state = S_ACYC;
                end else begin
                    o_cmd.root_adv = 1'b1;
                    if (i_stat.root_ok) begin
                        o_cmd.root_take = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    // finish the top node once the result register can take it
                    if (i_stat.out_free) begin
                        o_cmd.pop  = 1'b1;
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = KIND_POST;
                        o_cmd.nsel = NSEL_TOP;
                        if (i_stat.depth_one) n_state = S_ROOT;
                    end
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    if (i_stat.edge_white) begin
                        o_cmd.push = 1'b1;
                    end else if (i_stat.edge_gray) begin
                        o_cmd.gray_hit = 1'b1;
                        n_state        = S_FIND;
                    end
                end
            end
            S_FIND: begin
                o_cmd.k_rd = 1'b1;
                if (!i_stat.k_end && !i_stat.k_match) o_cmd.k_inc = 1'b1;
                else n_state = S_PATH;
            end
            S_PATH: begin
                o_cmd.k_rd = 1'b1;
                if (i_stat.k_end) begin
                    n_state = S_CLOSE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.kind  = KIND_PATH;
                    o_cmd.nsel  = NSEL_PATH;
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_CLOSE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_PATH;
                    o_cmd.nsel = NSEL_START;
                    n_state    = S_CYC;
                end
            end
            S_CYC: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_DONE_CYCLE;
                    o_cmd.nsel = NSEL_ZERO;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_ACYC: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_DONE_ACYC;
                    o_cmd.nsel = NSEL_ZERO;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/dfs_topological_order_cycle_check.sv =====
// Depth-first search over a loaded directed graph of 16 nodes: topological
// post-order output with first-cycle detection. Declare, edge and clear
// transactions update the adjacency matrix at once. A run transaction holds
// the input off until its final status result has been loaded into the
// output register. A run steps through the root slots, tests the adjacency
// columns of each visited node one neighbor per cycle, and emits one result
// per finished node and then the status result. On a cycle it locates the
// cycle start on the stack, then emits the path results and the closing node.
// Output stalls hold the run back. Graph, colors and flags sit in flip-flops
// that reset clears, so no clearing pass follows reset.
module dfs_topological_order_cycle_check import dfsc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dfsc_item_if.sink      i_item,
    dfsc_result_if.source  o_result
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_load;

    assign i_item.ready = w_in_ready;
    assign w_load       = i_item.valid && w_in_ready;

    dfsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_opcode   (i_item.opcode),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    dfsc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_opcode    (i_item.opcode),
        .i_src       (i_item.src_node),
        .i_dst       (i_item.dst_node),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_res_valid (o_result.valid),
        .i_res_ready (o_result.ready),
        .o_kind      (o_result.kind),
        .o_node      (o_result.node),
        .o_last      (o_result.last)
    );

endmodule

// ===== rtl/dfsc_checker.sv =====
// Port-level checker for the DFS cycle checker and its bind to the top level.
module dfsc_checker import dfsc_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input t_code i_opcode,
    input logic  i_res_valid,
    input logic  i_res_ready,
    input t_code i_kind,
    input t_node i_node,
    input logic  i_last
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_kind) && $stable(i_node) && $stable(i_last))
        else $error("result changed while stalled");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |->
            (i_last == (i_kind == KIND_DONE_ACYC || i_kind == KIND_DONE_CYCLE)))
        else $error("last flag does not match a status result");

    a_status_node_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_kind == KIND_DONE_ACYC || i_kind == KIND_DONE_CYCLE) |->
            i_node == '0)
        else $error("status result carries a node");

    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_opcode == OP_RUN |=> !i_in_ready)
        else $error("input accepted right after a run started");

endmodule

bind dfs_topological_order_cycle_check dfsc_checker u_dfsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_opcode    (i_item.opcode),
    .i_res_valid (o_result.valid),
    .i_res_ready (o_result.ready),
    .i_kind      (o_result.kind),
    .i_node      (o_result.node),
    .i_last      (o_result.last)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the graph depth-first search and cycle checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dfsc_pkg::*;

    localparam int LIMIT = 1_000_000;

    typedef struct packed {
        t_code op;
        t_node src;
        t_node dst;
    } t_graph_cmd;

    typedef struct packed {
        t_code kind;
        t_node node;
        logic  last;
    } t_walk_step;

    logic i_clk;
    logic i_rst_n;

    dfsc_item_if   item_bus ();
    dfsc_result_if result_bus ();

    dfs_topological_order_cycle_check u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    t_graph_cmd cmd_q [$];
    t_walk_step expected_walk [$];
    t_walk_step observed_walk [$];

    // Mirror of the graph held by the block
    logic [NODES-1:0] adj_rows [NODES] = '{default: '0};
    logic [NODES-1:0] decl_mask = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_len = 0;
    int hold_tag = 0;
    int hold_tag_seen = 0;
    int hold_left = 0;

    int err_cnt = 0;
    int cmd_cnt = 0;
    int search_cnt = 0;
    int loop_cnt = 0;
    int result_cnt = 0;
    int cycle_cnt = 0;

    initial begin
        i_clk = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.opcode = OP_DECLARE;
        item_bus.src_node = '0;
        item_bus.dst_node = '0;
        result_bus.ready = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
        $display("testbench NOT OK");
        $finish;
    end

    function automatic void expect_step(t_code kind, t_node node, logic last);
        expected_walk.insert(expected_walk.size(), t_walk_step'{kind, node, last});
    endfunction

    // Apply one accepted transaction to the mirror; a search queues its results
    function automatic void predict_item(t_code op, t_node s, t_node d);
        t_code      color [NODES];
        t_node      stk_node [NODES];
        logic [4:0] stk_next [NODES];
        int         depth;
        int         top;
        int         k;
        t_node      u;
        t_node      w;
        t_node      loop_head;
        logic       found;
        logic       pushed;
        case (op)
            OP_DECLARE: begin
                decl_mask[s] = 1'b1;
            end
            OP_EDGE: begin
                decl_mask[s] = 1'b1;
                adj_rows[s][d] = 1'b1;
            end
            OP_CLEAR: begin
                foreach (adj_rows[i]) adj_rows[i] = '0;
                decl_mask = '0;
            end
            default: begin
                search_cnt++;
                foreach (color[i]) color[i] = COLOR_WHITE;
                found = 1'b0;
                depth = 0;
                loop_head = '0;
                for (int r = 0; r < NODES && !found; r++) begin
                    if (!decl_mask[r] || color[r] != COLOR_WHITE) continue;
                    color[r] = COLOR_GRAY;
                    stk_node[0] = t_node'(r);
                    stk_next[0] = '0;
                    depth = 1;
                    while (depth > 0 && !found) begin
                        top = depth - 1;
                        u = stk_node[top];
                        pushed = 1'b0;
                        while (stk_next[top] < NODES && !found && !pushed) begin
                            w = stk_next[top][3:0];
                            stk_next[top]++;
                            if (adj_rows[u][w]) begin
                                if (color[w] == COLOR_WHITE) begin
                                    color[w] = COLOR_GRAY;
                                    if (depth < NODES) begin
                                        stk_node[depth] = w;
                                        stk_next[depth] = '0;
                                        depth++;
                                    end
                                    pushed = 1'b1;
                                end else if (color[w] == COLOR_GRAY) begin
                                    loop_head = w;
                                    found = 1'b1;
                                end
                            end
                        end
                        if (!found && !pushed) begin
                            expect_step(KIND_POST, u, 1'b0);
                            color[u] = COLOR_BLACK;
                            depth--;
                        end
                    end
                end
                if (found) begin
                    k = 0;
                    while (k < depth && stk_node[k] != loop_head) k++;
                    for (; k < depth; k++) expect_step(KIND_PATH, stk_node[k], 1'b0);
                    expect_step(KIND_PATH, loop_head, 1'b0);
                    expect_step(KIND_DONE_CYCLE, '0, 1'b1);
                end else begin
                    expect_step(KIND_DONE_ACYC, '0, 1'b1);
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : drive_items
        t_graph_cmd nxt_cmd;
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
        end else begin
            if (item_bus.valid && item_bus.ready)
                predict_item(item_bus.opcode, item_bus.src_node, item_bus.dst_node);
            if (!item_bus.valid || item_bus.ready) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt_cmd = cmd_q.pop_front();
                    item_bus.valid <= 1'b1;
                    item_bus.opcode <= nxt_cmd.op;
                    item_bus.src_node <= nxt_cmd.src;
                    item_bus.dst_node <= nxt_cmd.dst;
                end else begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_tag != hold_tag_seen) begin
            hold_tag_seen <= hold_tag;
            hold_left <= hold_len;
            result_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready)
            observed_walk.insert(observed_walk.size(),
                                 t_walk_step'{result_bus.kind, result_bus.node,
                                              result_bus.last});
    end

    // Fields are shown as kind/node/last
    always @(negedge i_clk) begin : check_walk
        t_walk_step got;
        t_walk_step want;
        while (observed_walk.size() != 0 && expected_walk.size() != 0) begin
            got = observed_walk.pop_front();
            want = expected_walk.pop_front();
            result_cnt++;
            if (want.kind == KIND_DONE_CYCLE) loop_cnt++;
            if (got !== want) begin
                err_cnt++;
                $display("%0t: result mismatch, expected %0d/%0d/%0d, got %0d/%0d/%0d",
                         $time, want.kind, want.node, want.last, got.kind, got.node,
                         got.last);
            end
        end
        if (observed_walk.size() != 0) begin
            foreach (observed_walk[i]) begin
                err_cnt++;
                $display("%0t: unexpected result, expected none, got %0d/%0d/%0d",
                         $time, observed_walk[i].kind, observed_walk[i].node,
                         observed_walk[i].last);
            end
            observed_walk.delete();
        end
    end

    function automatic t_node rnd_node();
        return t_node'($urandom_range(NODES - 1));
    endfunction

    function automatic void send(t_code op, t_node s, t_node d);
        cmd_q.insert(cmd_q.size(), t_graph_cmd'{op, s, d});
        cmd_cnt++;
    endfunction

    // Build one graph with random content, then search it
    task automatic queue_round();
        int order [NODES];
        int i;
        int j;
        int tmp;
        int style;
        style = $urandom_range(9);
        if ($urandom_range(99) < 70) send(OP_CLEAR, rnd_node(), rnd_node());
        if (style <= 3) begin
            repeat ($urandom_range(3)) send(OP_DECLARE, rnd_node(), rnd_node());
            repeat ($urandom_range(12, 1)) begin
                i = $urandom_range(NODES - 2);
                j = $urandom_range(NODES - 1, i + 1);
                send(OP_EDGE, t_node'(i), t_node'(j));
            end
        end else if (style <= 6) begin
            repeat ($urandom_range(2)) send(OP_DECLARE, rnd_node(), rnd_node());
            repeat ($urandom_range(8, 1)) send(OP_EDGE, rnd_node(), rnd_node());
        end else if (style <= 8) begin
            // chain through every node in shuffled order, closed into a ring half the time
            foreach (order[n]) order[n] = n;
            for (i = NODES - 1; i > 0; i--) begin
                j = $urandom_range(i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (i = 0; i < NODES - 1; i++)
                send(OP_EDGE, t_node'(order[i]), t_node'(order[i + 1]));
            if ($urandom_range(1) == 1)
                send(OP_EDGE, t_node'(order[NODES - 1]), t_node'(order[0]));
        end else begin
            repeat ($urandom_range(6, 1))
                send(t_code'($urandom_range(3)), rnd_node(), rnd_node());
        end
        send(OP_RUN, rnd_node(), rnd_node());
        if ($urandom_range(3) == 0) send(OP_RUN, rnd_node(), rnd_node());
    endtask

    task automatic drain(int settle);
        while (cmd_q.size() != 0 || item_bus.valid === 1'b1 || expected_walk.size() != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic run_phase(int idle_pct, int block_pct, int n_cmds);
        int start;
        send_idle_pct = idle_pct;
        stall_pct = block_pct;
        start = cmd_cnt;
        while (cmd_cnt - start < n_cmds) queue_round();
        drain(40);
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty graph, undeclared edge target, repeated search, back edge,
        // self loop, clear, and the extreme node indexes
        send(OP_RUN, 4'd0, 4'd0);
        send(OP_DECLARE, 4'd15, 4'd15);
        send(OP_DECLARE, 4'd0, 4'd0);
        send(OP_EDGE, 4'd3, 4'd5);
        send(OP_EDGE, 4'd5, 4'd15);
        send(OP_EDGE, 4'd0, 4'd3);
        send(OP_RUN, 4'd15, 4'd15);
        send(OP_RUN, 4'd0, 4'd15);
        send(OP_EDGE, 4'd15, 4'd3);
        send(OP_RUN, 4'd15, 4'd0);
        send(OP_CLEAR, 4'd0, 4'd0);
        send(OP_EDGE, 4'd7, 4'd7);
        send(OP_RUN, 4'd0, 4'd0);
        send(OP_CLEAR, 4'd15, 4'd15);
        send(OP_EDGE, 4'd15, 4'd0);
        send(OP_DECLARE, 4'd8, 4'd15);
        send(OP_RUN, 4'd0, 4'd0);
        drain(40);

        run_phase(0, 0, 60);
        run_phase(78, 0, 80);
        run_phase(0, 78, 80);
        run_phase(9, 9, 60);

        // Hold the result side off while long searches keep arriving
        send_idle_pct = 0;
        stall_pct = 0;
        hold_len = 500;
        hold_tag++;
        repeat (3) queue_round();
        drain(400);

        $display("Covered %0d transactions with %0d searches (%0d ending on a cycle)",
                 cmd_cnt, search_cnt, loop_cnt);
        $display("Checked %0d results in %0d cycles, %0d errors", result_cnt, cycle_cnt,
                 err_cnt);
        if (err_cnt == 0 && expected_walk.size() == 0 && observed_walk.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
